// File: sv/bdpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdpd_pkg: shared types and constants of the byte destuff/parity deframer
// Character codes, result kinds and the transaction type that passes from
// the destuffing front end through the queue to the parity back end.
// ----------------------------------------------------------------------------
package bdpd_pkg;

  localparam logic [7:0] FLAG_CHAR  = 8'h7E;  // '~'
  localparam logic [7:0] FLAG_ESC2  = 8'h5E;  // '^'
  localparam logic [7:0] CTRL_CHAR  = 8'h7D;  // '}'
  localparam logic [7:0] CTRL_ESC2  = 8'h33;  // '3'
  localparam logic [7:0] TERM_CHAR  = 8'h08;  // backspace terminator
  localparam logic [7:0] DIGIT_ZERO = 8'h30;  // '0'

  // Queue geometry
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Result kinds on the output stream
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // Operation passed from front to back
  typedef enum logic {
    OP_DATA = 1'b0,  // emit a payload byte
    OP_END  = 1'b1   // terminator seen: check the held digit
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       held_valid;  // OP_END only: a digit candidate was held
    logic [7:0] value;       // payload byte, or held digit candidate
  } op_t;

endpackage : bdpd_pkg
`default_nettype wire

// File: sv/bdpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdpd_front: flag stripping and escape removal
// Consumes one raw byte per transaction, keeps the destuffing state and
// issues data or end-of-frame operations towards the queue.
// ----------------------------------------------------------------------------
module bdpd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           take_i,   // raw byte accepted this cycle
  input  wire logic [7:0]     byte_i,
  output bdpd_pkg::op_t       op_o,
  output logic                push_o
);
  import bdpd_pkg::*;

  logic       at_start_q, at_start_d;
  logic       esc_pend_q, esc_pend_d;
  logic [7:0] esc_char_q, esc_char_d;
  logic       held_vld_q, held_vld_d;
  logic [7:0] held_q,     held_d;
  logic       pair;

  assign pair = ((esc_char_q == FLAG_CHAR) && (byte_i == FLAG_ESC2)) ||
                ((esc_char_q == CTRL_CHAR) && (byte_i == CTRL_ESC2));

  always_comb begin
    at_start_d = at_start_q;
    esc_pend_d = esc_pend_q;
    esc_char_d = esc_char_q;
    held_vld_d = held_vld_q;
    held_d     = held_q;
    push_o     = 1'b0;
    op_o       = '{op: OP_DATA, held_valid: 1'b0, value: held_q};
    if (take_i) begin
      priority if (byte_i == TERM_CHAR) begin
        push_o     = 1'b1;
        op_o       = '{op: OP_END, held_valid: held_vld_q, value: held_q};
        at_start_d = 1'b1;
        esc_pend_d = 1'b0;
        esc_char_d = '0;
        held_vld_d = 1'b0;
        held_d     = '0;
      end else if (at_start_q) begin
        at_start_d = 1'b0;          // opening flag dropped
      end else if (!esc_pend_q) begin
        esc_pend_d = 1'b1;
        esc_char_d = byte_i;
      end else begin
        // Destuffed byte is esc_char_q; the held one moves out as payload
        if (pair) begin
          esc_pend_d = 1'b0;
          esc_char_d = '0;
        end else begin
          esc_char_d = byte_i;
        end
        push_o     = held_vld_q;
        held_d     = esc_char_q;
        held_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      esc_pend_q <= 1'b0;
      esc_char_q <= '0;
      held_vld_q <= 1'b0;
      held_q     <= '0;
    end else begin
      at_start_q <= at_start_d;
      esc_pend_q <= esc_pend_d;
      esc_char_q <= esc_char_d;
      held_vld_q <= held_vld_d;
      held_q     <= held_d;
    end
  end

endmodule : bdpd_front
`default_nettype wire

// File: sv/bdpd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdpd_queue: short operation queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bdpd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bdpd_pkg::op_t  op_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bdpd_pkg::op_t       op_o
);
  import bdpd_pkg::*;

  op_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule : bdpd_queue
`default_nettype wire

// File: sv/bdpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdpd_back: parity tracking and result register
// Pops operations, keeps the running parity of payload bytes, judges the
// parity digit at frame end and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bdpd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire bdpd_pkg::op_t  q_op_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bdpd_pkg::kind_e     kind_o,
  output logic [7:0]          data_o
);
  import bdpd_pkg::*;

  logic       parity_q;
  logic       vld_q;
  kind_e      kind_q, kind_d;
  logic [7:0] data_q, data_d;
  logic       good;

  assign q_pop_o = q_valid_i && (!vld_q || out_ready_i);
  assign good    = q_op_i.held_valid &&
                   (q_op_i.value == {DIGIT_ZERO[7:1], parity_q});

  always_comb begin
    unique case (q_op_i.op)
      OP_DATA: begin
        kind_d = KIND_DATA;
        data_d = q_op_i.value;
      end
      OP_END: begin
        kind_d = good ? KIND_GOOD : KIND_BAD;
        data_d = '0;
      end
      default: begin
        kind_d = KIND_BAD;
        data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      if (q_pop_o) begin
        vld_q    <= 1'b1;
        parity_q <= (q_op_i.op == OP_END) ? 1'b0 : (parity_q ^ q_op_i.value[0]);
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q <= kind_d;
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;

endmodule : bdpd_back
`default_nettype wire

// File: sv/byte_destuff_parity_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_destuff_parity_deframer: stuffed byte stream deframer with parity
// Strips opening/closing flags, undoes "~^" and "}3" escapes, withholds the
// trailing parity digit and reports good/bad parity at each terminator.
//
//  channel   dir  tdata bits (low first)  tuser       tlast
//  s_axis    in   [7:0] rx_byte           -           -
//  m_axis    out  [7:0] data_byte         [1:0] kind  last_of_run
//
//  Raw bytes are taken one per cycle while the queue has room; each gives
//  at most one result. Front end updates destuff state in the accept cycle;
//  a result is written into the 4-deep queue, then into the output register.
//  s_axis_tready_o drops only when the queue is full (output stalled).
//  Asynchronous active-low reset returns to start-of-frame, empty queue.
// ----------------------------------------------------------------------------
module byte_destuff_parity_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // raw input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] data_byte
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o    // last_of_run
);
  import bdpd_pkg::*;

  logic       take;
  logic       push;
  op_t        push_op;
  logic       q_full;
  logic       q_valid;
  op_t        q_op;
  logic       q_pop;
  kind_e      kind;
  logic [7:0] data;

  // Input transaction completes whenever the queue has room
  assign s_axis_tready_o = !q_full;
  assign take            = s_axis_tvalid_i && !q_full;

  bdpd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (s_axis_tdata_i),
    .op_o   (push_op),
    .push_o (push)
  );

  bdpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  bdpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (kind),
    .data_o      (data)
  );

  // Every raw byte yields at most one result, so each one closes its run
  assign m_axis_tdata_o = data;
  assign m_axis_tuser_o = kind;
  assign m_axis_tlast_o = 1'b1;

endmodule : byte_destuff_parity_deframer
`default_nettype wire

// File: dv/tb_byte_destuff_parity_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_byte_destuff_parity_deframer: self-checking bench for the deframer
// Drives raw stuffed bytes into the input stream. A behavioural model of the
// destuffer predicts every payload byte and frame status. A checker compares
// each output transaction with the oldest prediction. Directed cases come
// first, then random frames and noise under three idle patterns, with a long
// output stall and pauses that drain the block.
// ----------------------------------------------------------------------------
module tb_byte_destuff_parity_deframer;
  import bdpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned SETTLE_TICKS = 8;  // idle ticks after the last prediction is met

  // one output transaction as the block should produce it
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  // ---- DUT signals, inputs known from time zero --------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;   // [7:0] rx_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;            // [7:0] data_byte
  logic [1:0]  m_axis_tuser_o;            // [1:0] kind
  logic        m_axis_tlast_o;            // last_of_run

  // ---- bench state -----------------------------------------------------------
  frame_result_t pending_results[$];
  int unsigned   err_cnt    = 0;
  int unsigned   cyc_cnt    = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   hold_left     = 0;     // long receiver stall, in cycles

  // model copy of the destuffing state
  bit          st_at_start = 1'b1;
  bit          st_esc_pend = 1'b0;
  logic [7:0]  st_esc_byte = 8'h00;
  bit          st_held_v   = 1'b0;
  logic [7:0]  st_held     = 8'h00;
  bit          st_parity   = 1'b0;

  byte_destuff_parity_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // ---- run guard: a hung handshake ends the run here --------------------------
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("byte_destuff_parity_deframer verification failed");
      $finish;
    end
  end

  // ---- receiver: random back-pressure, or a long stall when requested ---------
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---- model: one accepted raw byte in, zero or one predicted result out ------
  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0]    c;
    bit            pair;
    if (b == TERM_CHAR) begin
      // terminator ends the frame anywhere; status from held digit vs parity
      if (st_held_v && (st_held == (DIGIT_ZERO | {7'd0, st_parity})))
        r.kind = KIND_GOOD;
      else
        r.kind = KIND_BAD;
      r.data = 8'h00;
      r.last = 1'b1;
      pending_results.push_back(r);
      st_at_start = 1'b1;
      st_esc_pend = 1'b0;
      st_esc_byte = 8'h00;
      st_held_v   = 1'b0;
      st_held     = 8'h00;
      st_parity   = 1'b0;
    end else if (st_at_start) begin
      st_at_start = 1'b0;               // opening flag, whatever it is
    end else if (!st_esc_pend) begin
      st_esc_pend = 1'b1;
      st_esc_byte = b;
    end else begin
      // two-byte window: a pair collapses, anything else slides on by one
      c    = st_esc_byte;
      pair = (c == FLAG_CHAR && b == FLAG_ESC2) || (c == CTRL_CHAR && b == CTRL_ESC2);
      if (pair) begin
        st_esc_pend = 1'b0;
        st_esc_byte = 8'h00;
      end else begin
        st_esc_byte = b;
      end
      // the held byte is only released once a newer one replaces it
      if (st_held_v) begin
        r.kind = KIND_DATA;
        r.data = st_held;
        r.last = 1'b1;
        pending_results.push_back(r);
        st_parity = st_parity ^ st_held[0];
      end
      st_held   = c;
      st_held_v = 1'b1;
    end
  endtask

  // ---- mismatch report ------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0d] MISMATCH %s: got 0x%0h, expected 0x%0h", cyc_cnt, what, got, want);
    err_cnt++;
  endtask

  // ---- checker: every output transaction against the oldest prediction -------------
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", {8'd0, m_axis_tdata_o}, 16'h0000);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o !== want.kind)
          report_mismatch("kind", {14'd0, m_axis_tuser_o}, {14'd0, want.kind});
        if (m_axis_tdata_o !== want.data)
          report_mismatch("data_byte", {8'd0, m_axis_tdata_o}, {8'd0, want.data});
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last_of_run", {15'd0, m_axis_tlast_o}, {15'd0, want.last});
      end
    end
  end

  // ---- sender: optional idle cycles, then hold the byte until taken -------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // lower valid, wait for every prediction to be met, let the pipe settle
  task automatic drain_block();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // payload byte: specials weighted in, never the terminator
  function automatic logic [7:0] pick_payload();
    logic [7:0] v;
    case ($urandom_range(0, 11))
      0:       v = FLAG_CHAR;
      1:       v = CTRL_CHAR;
      2:       v = FLAG_ESC2;
      3:       v = CTRL_ESC2;
      4:       v = 8'h00;
      5:       v = 8'hFF;
      default: begin
        v = 8'($urandom_range(0, 255));
        if (v == TERM_CHAR) v = 8'hF7;
      end
    endcase
    return v;
  endfunction

  // raw noise byte: terminator and escape starters are common
  function automatic logic [7:0] pick_noise();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0:       v = FLAG_CHAR;
      1:       v = CTRL_CHAR;
      2:       v = FLAG_ESC2;
      3:       v = CTRL_ESC2;
      4:       v = TERM_CHAR;
      5:       v = DIGIT_ZERO;
      6:       v = DIGIT_ZERO + 8'd1;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // Well-formed frame: flag, stuffed payload, digit, flag, terminator.
  // digit_mode 0: correct digit, 1: inverted digit, 2: arbitrary byte.
  // cut > 0 stops after that many raw bytes and ends with a terminator.
  task automatic send_frame(input int unsigned len, input int unsigned digit_mode,
                            input int unsigned cut);
    logic [7:0]  raw[$];
    logic [7:0]  p;
    logic [7:0]  digit;
    bit          par;
    int unsigned n;
    par = 1'b0;
    raw.push_back(FLAG_CHAR);
    for (int unsigned i = 0; i < len; i++) begin
      p   = pick_payload();
      par = par ^ p[0];
      if (p == FLAG_CHAR) begin
        raw.push_back(FLAG_CHAR);
        raw.push_back(FLAG_ESC2);
      end else if (p == CTRL_CHAR) begin
        raw.push_back(CTRL_CHAR);
        raw.push_back(CTRL_ESC2);
      end else begin
        raw.push_back(p);
      end
    end
    case (digit_mode)
      0:       digit = DIGIT_ZERO | {7'd0, par};
      1:       digit = DIGIT_ZERO | {7'd0, ~par};
      default: begin
        digit = pick_payload();
        if (digit == FLAG_CHAR || digit == CTRL_CHAR) digit = 8'h41;
      end
    endcase
    raw.push_back(digit);
    raw.push_back(FLAG_CHAR);
    raw.push_back(TERM_CHAR);
    n = (cut != 0 && cut < raw.size()) ? cut : raw.size();
    for (int unsigned i = 0; i < n; i++) send_byte(raw[i]);
    if (n != raw.size()) send_byte(TERM_CHAR);
  endtask

  // ---- directed cases ---------------------------------------------------------------
  task automatic test_directed_cases();
    // terminator straight after reset: empty frame, bad
    send_byte(TERM_CHAR);
    // zero and all-ones bytes plus both escape pairs; parity 0 -> digit '0'
    send_byte(FLAG_CHAR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(FLAG_CHAR);
    send_byte(FLAG_ESC2);
    send_byte(CTRL_CHAR);
    send_byte(CTRL_ESC2);
    send_byte(DIGIT_ZERO);
    send_byte(FLAG_CHAR);
    send_byte(TERM_CHAR);
    // unpaired escape start passes through; '}' ^ 'A' bit 0 is 0 -> '0'
    send_byte(FLAG_CHAR);
    send_byte(CTRL_CHAR);
    send_byte(8'h41);
    send_byte(DIGIT_ZERO);
    send_byte(FLAG_CHAR);
    send_byte(TERM_CHAR);
    // terminator inside a body, nothing held yet
    send_byte(FLAG_CHAR);
    send_byte(8'h55);
    send_byte(TERM_CHAR);
    // wrong digit: payload 0x01 wants '1'
    send_byte(FLAG_CHAR);
    send_byte(8'h01);
    send_byte(DIGIT_ZERO);
    send_byte(FLAG_CHAR);
    send_byte(TERM_CHAR);
    // back-to-back terminator after that one
    send_byte(TERM_CHAR);
    drain_block();
  endtask

  // ---- random traffic: mostly valid frames, some noise and broken frames -----------
  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0:       repeat ($urandom_range(1, 12)) send_byte(pick_noise());
        1:       send_frame(len, $urandom_range(0, 2), $urandom_range(1, len + 3));
        2:       send_frame(len, $urandom_range(1, 2), 0);
        default: send_frame(len, 0, 0);
      endcase
    end
    drain_block();
  endtask

  // ---- long output stall: the queue fills and the input must stall -------------
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_left = 300;
    repeat (6) send_frame($urandom_range(4, 8), 0, 0);
    drain_block();
  endtask

  // ---- sequence ------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drain_block();

    test_directed_cases();
    test_random_traffic(37, 45, 600);
    test_output_stall();
    test_random_traffic(45, 37, 600);
    test_random_traffic(0, 0, 600);

    if (err_cnt == 0) begin
      $display("byte_destuff_parity_deframer verification clean");
    end else begin
      $display("byte_destuff_parity_deframer verification failed");
    end
    $finish;
  end

endmodule : tb_byte_destuff_parity_deframer
`default_nettype wire
